@@ sv/bkt_pkg.sv @@
// shared types and constants for the bucketizer core
package bkt_pkg;

  localparam int MAX_B  = 64;                  // table depth
  localparam int VW     = 32;                  // boundary and sample width
  localparam int SLOT_W = $clog2(MAX_B);       // table slot index width
  localparam int CNT_W  = $clog2(MAX_B + 1);   // bucket and count width
  localparam int STEPS  = $clog2(MAX_B) + 1;   // halving steps for a full table

  typedef enum logic {
    CMD_LOAD     = 1'b0,
    CMD_CLASSIFY = 1'b1
  } cmd_t;

  // request travelling along the cell row
  typedef struct packed {
    logic              vld;
    cmd_t              cmd;
    logic [SLOT_W-1:0] slot;
    logic [VW-1:0]     value;   // order key: sign bit flipped
    logic [MAX_B-1:0]  hits;    // per slot: key at or above boundary
  } tok_t;

  // search state handed between halving steps
  typedef struct packed {
    logic             vld;
    logic [MAX_B-1:0] hits;
    logic [CNT_W-1:0] bucket;
    logic [CNT_W-1:0] count;
  } srch_t;

endpackage

@@ sv/bkt_cell.sv @@
// one table cell: holds a boundary and marks passing samples against it
module bkt_cell (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      en,
  input  logic [bkt_pkg::SLOT_W-1:0] cell_idx,
  input  bkt_pkg::tok_t             tok_i,
  output bkt_pkg::tok_t             tok_o
);

  logic [bkt_pkg::VW-1:0] bound_r;
  bkt_pkg::tok_t          tok_r;
  bkt_pkg::tok_t          tok_nxt;

  always_comb begin
    tok_nxt = tok_i;
    if (tok_i.vld && tok_i.cmd == bkt_pkg::CMD_CLASSIFY) begin
      tok_nxt.hits[cell_idx] = (tok_i.value >= bound_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r.vld <= 1'b0;
    end else if (en) begin
      tok_r <= tok_nxt;
    end
  end

  // load lands when it reaches its own slot, so order with samples holds
  always_ff @(posedge clk) begin
    if (en && tok_i.vld && tok_i.cmd == bkt_pkg::CMD_LOAD && tok_i.slot == cell_idx) begin
      bound_r <= tok_i.value;
    end
  end

  assign tok_o = tok_r;

endmodule

@@ sv/bkt_search_step.sv @@
// one halving step of the upper-bound search over the hit vector
module bkt_search_step (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  bkt_pkg::srch_t  srch_i,
  output bkt_pkg::srch_t  srch_o
);

  bkt_pkg::srch_t srch_r;
  bkt_pkg::srch_t srch_nxt;

  always_comb begin
    logic [bkt_pkg::CNT_W-1:0] half;
    logic [bkt_pkg::CNT_W-1:0] probe;
    half  = srch_i.count >> 1;
    probe = srch_i.bucket + half;
    srch_nxt = srch_i;
    if (srch_i.count != '0) begin
      if (srch_i.hits[probe[bkt_pkg::SLOT_W-1:0]]) begin
        srch_nxt.bucket = probe + bkt_pkg::CNT_W'(1);
        srch_nxt.count  = srch_i.count - half - bkt_pkg::CNT_W'(1);
      end else begin
        srch_nxt.count  = half;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      srch_r.vld <= 1'b0;
    end else if (en) begin
      srch_r <= srch_nxt;
    end
  end

  assign srch_o = srch_r;

endmodule

@@ sv/bucketize_upper_bound_core.sv @@
// top level of the bucketizer: cell row, halving search and ports
//
// usage
//   input channel (in_valid / in_ready): one request per handshake. in_command
//   selects a load (in_load_slot, in_load_boundary written into the table) or
//   a classify (in_sample). only classify requests give a result.
//   result channel (out_valid / out_ready): out_bucket is the upper-bound
//   position of the sample in the first boundary_count table slots.
//   config channel (cfg_valid / cfg_data): sets boundary_count, always ready;
//   write it only while no request is in flight.
// pipeline
//   a request walks the row of 64 cells, then 7 halving steps, each one
//   register stage. the row and the steps are fully pipelined, so one request
//   per cycle is sustained unless a waiting result stalls the pipeline.
// reset
//   all pipeline valids and boundary_count clear; table contents are
//   undefined until loaded.
// stall
//   while a result waits unaccepted the whole pipeline holds and in_ready is
//   low; nothing is lost or repeated.
module bucketize_upper_bound_core (
  input  logic                       clk,
  input  logic                       rst_n,
  // request channel
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       in_command,
  input  logic [bkt_pkg::SLOT_W-1:0] in_load_slot,
  input  logic [bkt_pkg::VW-1:0]     in_load_boundary,
  input  logic [bkt_pkg::VW-1:0]     in_sample,
  // result channel
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [bkt_pkg::CNT_W-1:0]  out_bucket,
  // config channel
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [bkt_pkg::CNT_W-1:0]  cfg_data
);

  logic                      adv;            // whole pipeline moves
  logic [bkt_pkg::CNT_W-1:0] bnd_count_r;
  logic [bkt_pkg::CNT_W-1:0] eff_count;      // count clamped to the table depth
  logic [bkt_pkg::VW-1:0]    in_value;
  bkt_pkg::cmd_t             in_cmd;

  bkt_pkg::tok_t  tok_chain [0:bkt_pkg::MAX_B];
  bkt_pkg::srch_t srch_chain [0:bkt_pkg::STEPS];

  // config register, no back-pressure
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bnd_count_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      bnd_count_r <= cfg_data;
    end
  end

  // global stall when the output register holds an untaken result
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  // signed values become unsigned keys of the same order
  assign in_cmd   = bkt_pkg::cmd_t'(in_command);
  assign in_value = (in_cmd == bkt_pkg::CMD_CLASSIFY) ? in_sample : in_load_boundary;

  always_comb begin
    tok_chain[0]       = '0;
    tok_chain[0].vld   = in_valid && in_ready;
    tok_chain[0].cmd   = in_cmd;
    tok_chain[0].slot  = in_load_slot;
    tok_chain[0].value = {~in_value[bkt_pkg::VW-1], in_value[bkt_pkg::VW-2:0]};
  end

  // row of table cells, loads and samples travel in order
  for (genvar g = 0; g < bkt_pkg::MAX_B; g++) begin : g_cell
    bkt_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (adv),
      .cell_idx (bkt_pkg::SLOT_W'(g)),
      .tok_i    (tok_chain[g]),
      .tok_o    (tok_chain[g+1])
    );
  end

  // counts above the depth search the whole table
  assign eff_count = (bnd_count_r > bkt_pkg::CNT_W'(bkt_pkg::MAX_B)) ?
                     bkt_pkg::CNT_W'(bkt_pkg::MAX_B) : bnd_count_r;

  // loads leave the pipe here; classifies start the search
  always_comb begin
    srch_chain[0].vld    = tok_chain[bkt_pkg::MAX_B].vld &&
                           (tok_chain[bkt_pkg::MAX_B].cmd == bkt_pkg::CMD_CLASSIFY);
    srch_chain[0].hits   = tok_chain[bkt_pkg::MAX_B].hits;
    srch_chain[0].bucket = '0;
    srch_chain[0].count  = eff_count;
  end

  // halving steps, last one doubles as the output register
  for (genvar s = 0; s < bkt_pkg::STEPS; s++) begin : g_step
    bkt_search_step u_step (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (adv),
      .srch_i (srch_chain[s]),
      .srch_o (srch_chain[s+1])
    );
  end

  assign out_valid  = srch_chain[bkt_pkg::STEPS].vld;
  assign out_bucket = srch_chain[bkt_pkg::STEPS].bucket;

endmodule

@@ sv/bkt_checker.sv @@
// port-level checks for the bucketizer core and their bind
module bkt_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_ready,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic [bkt_pkg::CNT_W-1:0] out_bucket
);

  // a waiting result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // and keeps its value
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_bucket))
    else $error("result changed while stalled");

  // a blocked result holds the request side too
  a_stall_link: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("request taken while pipeline stalled");

  // bucket never passes the table depth
  a_bucket_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_bucket <= bkt_pkg::CNT_W'(bkt_pkg::MAX_B))
    else $error("bucket beyond table depth");

  // reset empties the pipeline
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result offered after reset");

endmodule

bind bucketize_upper_bound_core bkt_checker u_bkt_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_ready   (in_ready),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .out_bucket (out_bucket)
);
